@@ src/fuzzy_lz_token_decoder_core_assert.svh @@
// Assertion macros for the fuzzy LZ token decoder.
// Expects signals named clk and rst in the including module.
`ifndef FUZZY_LZ_TOKEN_DECODER_CORE_ASSERT_SVH
`define FUZZY_LZ_TOKEN_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FLZ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FLZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/flz_pkg.sv @@
// Shared types and constants for the fuzzy LZ token decoder.
// No dependencies.
package flz_pkg;

  // History ring geometry
  localparam int HIST_DEPTH = 65536;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_CAPACITY = 1'b0;

  // Element kinds on the request channel
  localparam logic [2:0] REQ_TYPE  = 3'd0;
  localparam logic [2:0] REQ_LEN   = 3'd1;
  localparam logic [2:0] REQ_SLO   = 3'd2;
  localparam logic [2:0] REQ_SHI   = 3'd3;
  localparam logic [2:0] REQ_LIT   = 3'd4;
  localparam logic [2:0] REQ_FUZ   = 3'd5;
  localparam logic [2:0] REQ_COPY  = 3'd6;

  // Token kinds carried by a type token
  localparam logic [7:0] KIND_LITERAL = 8'd0;
  localparam logic [7:0] KIND_EXACT   = 8'd1;
  localparam logic [7:0] KIND_DIFF    = 8'd2;
  localparam logic [7:0] KIND_XOR     = 8'd3;

  localparam logic [7:0] LEN_RUN_BYTE = 8'd255;
  localparam logic [32:0] LEN_BIAS    = 33'd3;

  typedef enum logic [2:0] {
    ST_BYTE       = 3'd0,
    ST_BAD_DIST   = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_UNEXPECTED = 3'd3,
    ST_CAPACITY   = 3'd4
  } status_t;

  // Element the decoder waits for
  typedef enum logic [6:0] {
    EXP_TYPE = 7'b0000001,
    EXP_LEN  = 7'b0000010,
    EXP_SLO  = 7'b0000100,
    EXP_SHI  = 7'b0001000,
    EXP_LIT  = 7'b0010000,
    EXP_FUZ  = 7'b0100000,
    EXP_COPY = 7'b1000000
  } exp_t;

  // How the output stage forms its byte
  typedef enum logic [1:0] {
    MODE_LIT  = 2'd0,
    MODE_COPY = 2'd1,
    MODE_DIFF = 2'd2,
    MODE_XOR  = 2'd3
  } mode_t;

  // Output stage contents
  typedef struct packed {
    status_t              status;
    logic                 token_end;
    mode_t                mode;
    logic [7:0]           value;
    logic [HIST_AW-1:0]   addr;
    logic                 fwd_hit;
    logic [7:0]           fwd_data;
  } s1_t;

  // Request code that matches an expected element
  function automatic logic [2:0] exp_code(exp_t e);
    logic [2:0] c;
    unique case (e)
      EXP_TYPE: c = REQ_TYPE;
      EXP_LEN:  c = REQ_LEN;
      EXP_SLO:  c = REQ_SLO;
      EXP_SHI:  c = REQ_SHI;
      EXP_LIT:  c = REQ_LIT;
      EXP_FUZ:  c = REQ_FUZ;
      EXP_COPY: c = REQ_COPY;
      default:  c = REQ_TYPE;
    endcase
    return c;
  endfunction

endpackage

@@ src/flz_if.sv @@
// Request and response channel interfaces for the fuzzy LZ token decoder.
// Depends on flz_pkg.
interface flz_req_if import flz_pkg::*;;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] elem_value;

  modport source (output valid, req_type, elem_value, input ready);
  modport sink   (input valid, req_type, elem_value, output ready);
endinterface

interface flz_rsp_if import flz_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  status_t    status;
  logic       token_end;

  modport source (output valid, out_byte, status, token_end, input ready);
  modport sink   (input valid, out_byte, status, token_end, output ready);
endinterface

@@ src/fuzzy_lz_token_decoder_core.sv @@
// Fuzzy LZ token decoder: rebuilds bytes from serialized LZ elements.
// Depends on flz_pkg, flz_if and fuzzy_lz_token_decoder_core_assert.svh.
//
//   Channel  Dir  Handshake          Payload
//   req      in   valid/ready        req_type, elem_value
//   rsp      out  valid/ready        out_byte, status, token_end
//   apb      in   psel/penable/pwr   paddr, pwdata -> prdata (output_capacity)
//
// One element is taken per cycle unless stalled; a byte passes the output stage, then the output register.
// The pace is set by the 64 KiB history RAM: one read at accept, one write in
// the output stage, with the last written byte forwarded for distance one.
// rst is synchronous; the ring has no clear, all control state resets at once.
// A full output register with rsp.ready low stalls the output stage and req.
`include "fuzzy_lz_token_decoder_core_assert.svh"

module fuzzy_lz_token_decoder_core import flz_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  flz_req_if.sink           req,
  flz_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Decoder state
  logic [31:0] capacity;
  exp_t        expect_st, expect_st_next;
  logic [7:0]  token_kind, token_kind_next;
  logic [31:0] length_sum, length_sum_next;
  logic [7:0]  shift_low, shift_low_next;
  logic [15:0] distance, distance_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] wpos, wpos_next;
  logic        halted, halted_next;

  // Output stage and output register
  logic        s1_valid;
  s1_t         s1, s1_load_data;
  logic        s1_load, s1_adv;
  logic [7:0]  s1_byte, ref_byte;
  logic        out_valid;

  // History ring
  logic [7:0]         ring [HIST_DEPTH];
  logic [7:0]         rd_data;
  logic               mem_re, mem_we;
  logic [HIST_AW-1:0] rd_addr;

  logic        accept;
  logic [15:0] dist_in;
  logic [32:0] len_sum_wide, end_pos;
  logic        cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? capacity : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '1;
    end else if (cfg_wr) begin
      capacity <= pwdata;
    end
  end

  // Handshake
  assign s1_adv    = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;

  // Datapath helpers
  assign dist_in      = {req.elem_value, shift_low};
  assign rd_addr      = wpos[HIST_AW-1:0] - distance[HIST_AW-1:0];
  assign len_sum_wide = {1'b0, length_sum} + {25'd0, req.elem_value} +
                        ((req.elem_value != LEN_RUN_BYTE) ? LEN_BIAS : 33'd0);
  assign end_pos      = {1'b0, wpos} + {1'b0, length_sum};

  // Decode one element against the expected kind
  always_comb begin
    expect_st_next  = expect_st;
    token_kind_next = token_kind;
    length_sum_next = length_sum;
    shift_low_next  = shift_low;
    distance_next   = distance;
    remaining_next  = remaining;
    wpos_next       = wpos;
    halted_next     = halted;
    s1_load         = 1'b0;
    mem_re          = 1'b0;
    s1_load_data    = '0;
    s1_load_data.addr = wpos[HIST_AW-1:0];
    s1_load_data.value = req.elem_value;
    s1_load_data.status = ST_BYTE;
    if (accept && !halted) begin
      if (req.req_type != exp_code(expect_st)) begin
        halted_next = 1'b1;
        s1_load = 1'b1;
        s1_load_data.status = ST_UNEXPECTED;
      end else begin
        unique case (expect_st)
          EXP_TYPE: begin
            if (wpos >= capacity) begin
              halted_next = 1'b1;
              s1_load = 1'b1;
              s1_load_data.status = ST_CAPACITY;
            end else begin
              token_kind_next = req.elem_value;
              length_sum_next = '0;
              expect_st_next = (req.elem_value == KIND_LITERAL) ? EXP_LIT : EXP_LEN;
            end
          end
          EXP_LEN: begin
            length_sum_next = len_sum_wide[32] ? '1 : len_sum_wide[31:0];
            if (req.elem_value != LEN_RUN_BYTE) begin
              expect_st_next = EXP_SLO;
            end
          end
          EXP_SLO: begin
            shift_low_next = req.elem_value;
            expect_st_next = EXP_SHI;
          end
          EXP_SHI: begin
            if (dist_in == '0 || {16'd0, dist_in} > wpos) begin
              halted_next = 1'b1;
              s1_load = 1'b1;
              s1_load_data.status = ST_BAD_DIST;
            end else if (end_pos > {1'b0, capacity}) begin
              halted_next = 1'b1;
              s1_load = 1'b1;
              s1_load_data.status = ST_OVERFLOW;
            end else begin
              distance_next = dist_in;
              remaining_next = length_sum;
              if (token_kind == KIND_EXACT) begin
                expect_st_next = EXP_COPY;
              end else if (token_kind == KIND_DIFF || token_kind == KIND_XOR) begin
                expect_st_next = EXP_FUZ;
              end else begin
                expect_st_next = EXP_TYPE;
              end
            end
          end
          EXP_LIT: begin
            s1_load = 1'b1;
            s1_load_data.mode = MODE_LIT;
            s1_load_data.token_end = 1'b1;
            wpos_next = wpos + 32'd1;
            expect_st_next = EXP_TYPE;
          end
          EXP_FUZ, EXP_COPY: begin
            s1_load = 1'b1;
            mem_re = 1'b1;
            if (expect_st == EXP_COPY) begin
              s1_load_data.mode = MODE_COPY;
            end else if (token_kind == KIND_DIFF) begin
              s1_load_data.mode = MODE_DIFF;
            end else begin
              s1_load_data.mode = MODE_XOR;
            end
            s1_load_data.token_end = (remaining == 32'd1);
            // forward the byte being written now when it is the one read
            s1_load_data.fwd_hit = s1_valid && (s1.status == ST_BYTE) &&
                                   (s1.addr == rd_addr);
            s1_load_data.fwd_data = s1_byte;
            remaining_next = remaining - 32'd1;
            wpos_next = wpos + 32'd1;
            if (remaining == 32'd1) begin
              expect_st_next = EXP_TYPE;
            end
          end
          default: begin
            expect_st_next = EXP_TYPE;
          end
        endcase
      end
    end
  end

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_st  <= EXP_TYPE;
      token_kind <= '0;
      length_sum <= '0;
      shift_low  <= '0;
      distance   <= '0;
      remaining  <= '0;
      wpos       <= '0;
      halted     <= 1'b0;
    end else begin
      expect_st  <= expect_st_next;
      token_kind <= token_kind_next;
      length_sum <= length_sum_next;
      shift_low  <= shift_low_next;
      distance   <= distance_next;
      remaining  <= remaining_next;
      wpos       <= wpos_next;
      halted     <= halted_next;
    end
  end

  // Form the output byte from history or literal
  assign ref_byte = s1.fwd_hit ? s1.fwd_data : rd_data;

  always_comb begin
    if (s1.status != ST_BYTE) begin
      s1_byte = '0;
    end else begin
      unique case (s1.mode)
        MODE_LIT:  s1_byte = s1.value;
        MODE_COPY: s1_byte = ref_byte;
        MODE_DIFF: s1_byte = ref_byte + s1.value;
        MODE_XOR:  s1_byte = ref_byte ^ s1.value;
        default:   s1_byte = ref_byte;
      endcase
    end
  end

  assign mem_we = s1_valid && s1_adv && (s1.status == ST_BYTE);

  // History ring: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[s1.addr] <= s1_byte;
    end
    if (mem_re) begin
      rd_data <= ring[rd_addr];
    end
  end

  // Hold or advance the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= s1_load_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      rsp.out_byte  <= s1_byte;
      rsp.status    <= s1.status;
      rsp.token_end <= s1.token_end;
    end
  end

  assign rsp.valid = out_valid;

  // Checks
  `FLZ_ASSERT_NOW(a_halt_silent, halted, !s1_load, "result issued while halted")
  `FLZ_ASSERT_NEXT(a_wpos_step, 1'b1, (wpos - $past(wpos)) <= 32'd1, "write position jumped")
  `FLZ_ASSERT_NOW(a_fwd_byte, s1_valid && s1.fwd_hit, s1.status == ST_BYTE && s1.mode != MODE_LIT, "forward on non-history item")
  `FLZ_ASSERT_NOW(a_err_halts, s1_valid && s1.status != ST_BYTE, halted, "error result without halt")

endmodule
